// ===== hw/rtl/aqd_pkg.sv =====
// ----------------------------------------------------------------------------
// aqd_pkg
// Shared types, register codes and reset values of the quadrature decoder.
// ----------------------------------------------------------------------------
package aqd_pkg;

  // default storage widths
  localparam int unsigned TIME_WIDTH_DEF = 16;
  localparam int unsigned POS_WIDTH_DEF  = 16;

  // fixed field widths of the channels
  localparam int unsigned AB_W       = 2;
  localparam int unsigned NOW_W      = 16;
  localparam int unsigned POS_OUT_W  = 16;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // encoder line positions inside ab_sample
  localparam int unsigned LINE_A = 0;
  localparam int unsigned LINE_B = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_INTERVAL   = 4'd0,
    REG_MEDIUM_INTERVAL = 4'd1,
    REG_FAST_STEP       = 4'd2,
    REG_MEDIUM_STEP     = 4'd3
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [INTERVAL_W-1:0] FAST_INTERVAL_RST   = 16'd50;
  localparam logic [INTERVAL_W-1:0] MEDIUM_INTERVAL_RST = 16'd100;
  localparam logic [SIZE_W-1:0]     FAST_STEP_RST       = 4'd5;
  localparam logic [SIZE_W-1:0]     MEDIUM_STEP_RST     = 4'd2;
  localparam logic [SIZE_W-1:0]     SLOW_STEP           = 4'd1;

  // configuration as seen by the step logic
  typedef struct packed {
    logic [INTERVAL_W-1:0] fast_interval;
    logic [INTERVAL_W-1:0] medium_interval;
    logic [SIZE_W-1:0]     fast_step;
    logic [SIZE_W-1:0]     medium_step;
  } cfg_t;

  // decision for one sample
  typedef struct packed {
    logic                     step_taken;
    logic                     dir_up;
    logic signed [STEP_W-1:0] delta;
  } step_info_t;

endpackage

// ===== hw/rtl/aqd_sample_if.sv =====
// ----------------------------------------------------------------------------
// aqd_sample_if
// Sample channel: encoder lines and millisecond time, valid/ready.
// ----------------------------------------------------------------------------
interface aqd_sample_if;
  logic        valid;
  logic        ready;
  logic [1:0]  ab_sample;
  logic [15:0] now_ms;

  modport source (output valid, output ab_sample, output now_ms, input ready);
  modport sink (input valid, input ab_sample, input now_ms, output ready);
endinterface

// ===== hw/rtl/aqd_result_if.sv =====
// ----------------------------------------------------------------------------
// aqd_result_if
// Result channel: position and applied step, valid/ready.
// ----------------------------------------------------------------------------
interface aqd_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [4:0]  step_applied;

  modport source (output valid, output position, output step_applied, input ready);
  modport sink (input valid, input position, input step_applied, output ready);
endinterface

// ===== hw/rtl/aqd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aqd_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ----------------------------------------------------------------------------
interface aqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/aqd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aqd_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module aqd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  aqd_cfg_if.sink       cfg,
  output aqd_pkg::cfg_t regs
);
  import aqd_pkg::*;

  cfg_t regs_q;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  // register write on each transfer, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.fast_interval   <= FAST_INTERVAL_RST;
      regs_q.medium_interval <= MEDIUM_INTERVAL_RST;
      regs_q.fast_step       <= FAST_STEP_RST;
      regs_q.medium_step     <= MEDIUM_STEP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FAST_INTERVAL:   regs_q.fast_interval   <= cfg.data;
        REG_MEDIUM_INTERVAL: regs_q.medium_interval <= cfg.data;
        REG_FAST_STEP:       regs_q.fast_step       <= cfg.data[SIZE_W-1:0];
        REG_MEDIUM_STEP:     regs_q.medium_step     <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aqd_step_calc.sv =====
// ----------------------------------------------------------------------------
// aqd_step_calc
// Step detection, direction and speed-dependent step size for one sample.
// ----------------------------------------------------------------------------
module aqd_step_calc #(
  parameter int unsigned TIME_WIDTH = aqd_pkg::TIME_WIDTH_DEF
) (
  input  aqd_pkg::cfg_t         regs,
  input  logic [1:0]            ab,
  input  logic [1:0]            last_ab,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] last_up_time,
  input  logic [TIME_WIDTH-1:0] last_down_time,
  output aqd_pkg::step_info_t   info
);
  import aqd_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > INTERVAL_W) ? TIME_WIDTH : INTERVAL_W;

  logic                  b_change;
  logic                  dir_up;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CMP_W-1:0]      elapsed_ext;
  logic [CMP_W-1:0]      fast_ext;
  logic [CMP_W-1:0]      medium_ext;
  logic [SIZE_W-1:0]     size;
  logic [STEP_W-1:0]     size_ext;

  // a change of line b is a step; a differing from b means up
  assign b_change = ab[LINE_B] ^ last_ab[LINE_B];
  assign dir_up   = ab[LINE_A] ^ ab[LINE_B];

  // wrapping time since the last step in the same direction
  assign elapsed     = dir_up ? (now - last_up_time) : (now - last_down_time);
  assign elapsed_ext = CMP_W'(elapsed);
  assign fast_ext    = CMP_W'(regs.fast_interval);
  assign medium_ext  = CMP_W'(regs.medium_interval);

  // size selection, fast threshold first
  always_comb begin
    priority if (elapsed_ext < fast_ext) begin
      size = regs.fast_step;
    end else if (elapsed_ext < medium_ext) begin
      size = regs.medium_step;
    end else begin
      size = SLOW_STEP;
    end
  end

  assign size_ext = STEP_W'(size);

  // signed change, zero when line b held
  always_comb begin
    info.step_taken = b_change;
    info.dir_up     = dir_up;
    if (!b_change) begin
      info.delta = '0;
    end else if (dir_up) begin
      info.delta = size_ext;
    end else begin
      info.delta = -size_ext;
    end
  end

endmodule

// ===== hw/rtl/accelerated_quadrature_decoder.sv =====
// ----------------------------------------------------------------------------
// accelerated_quadrature_decoder
// Quadrature encoder decoder with a step size that grows with turning speed.
// ----------------------------------------------------------------------------
// Every sample of the encoder lines (bit 0 = A, bit 1 = B) with the current
// millisecond count gives exactly one result: the wrapping position after the
// sample and the signed step applied, zero when line B did not change. A step
// counts up when A differs from B, down otherwise; the time since the last
// step in that direction picks fast_step, medium_step or one. Samples are
// taken one per clock: a sample waits in the input register while the
// step logic works on it, the decoder state and the output register are
// updated together when it advances, and throughput is one sample per
// cycle, limited only by result backpressure.
// Configuration writes are taken at any time and should be made while no
// sample is in flight.
module accelerated_quadrature_decoder #(
  parameter int unsigned TIME_WIDTH     = aqd_pkg::TIME_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = aqd_pkg::POS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  aqd_cfg_if.sink      cfg,
  aqd_sample_if.sink   sample,
  aqd_result_if.source result
);
  import aqd_pkg::*;

  localparam int unsigned EXT_W =
    (POSITION_WIDTH > POS_OUT_W) ? POSITION_WIDTH : POS_OUT_W;

  cfg_t       regs;
  step_info_t info;

  // input register
  logic                  s1_valid;
  logic [1:0]            s1_ab;
  logic [TIME_WIDTH-1:0] s1_now;

  // decoder state
  logic [1:0]                last_ab;
  logic [TIME_WIDTH-1:0]     last_up_time;
  logic [TIME_WIDTH-1:0]     last_down_time;
  logic [POSITION_WIDTH-1:0] position_count;
  logic [POSITION_WIDTH-1:0] position_count_next;

  // result register
  logic                     out_valid;
  logic [POS_OUT_W-1:0]     out_position;
  logic [STEP_W-1:0]        out_step;
  logic signed [EXT_W-1:0]  pos_ext;

  logic advance;
  logic in_xfer;

  aqd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  aqd_step_calc #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step_calc (
    .regs           (regs),
    .ab             (s1_ab),
    .last_ab        (last_ab),
    .now            (s1_now),
    .last_up_time   (last_up_time),
    .last_down_time (last_down_time),
    .info           (info)
  );

  // handshake control
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign in_xfer      = sample.valid && sample.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ab  <= sample.ab_sample;
      s1_now <= TIME_WIDTH'(sample.now_ms);
    end
  end

  // position update, wrapping
  assign position_count_next = position_count + POSITION_WIDTH'(info.delta);
  assign pos_ext = EXT_W'($signed(position_count_next));

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab        <= '0;
      last_up_time   <= '0;
      last_down_time <= '0;
      position_count <= '0;
    end else if (advance) begin
      last_ab <= s1_ab;
      if (info.step_taken) begin
        position_count <= position_count_next;
        if (info.dir_up) begin
          last_up_time <= s1_now;
        end else begin
          last_down_time <= s1_now;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_position <= pos_ext[POS_OUT_W-1:0];
      out_step     <= info.delta;
    end
  end

  assign result.valid        = out_valid;
  assign result.position     = out_position;
  assign result.step_applied = out_step;

`ifndef SYNTHESIS
  // a sample with line b held reports no step
  a_no_step_without_b: assert property (@(posedge clk) disable iff (rst)
    advance && !info.step_taken |=> out_step == '0)
    else $error("step reported without a change of line b");

  // position moves only when a sample is processed
  a_position_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(position_count))
    else $error("position changed without a sample");

  // every processed sample yields a pending result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed sample produced no result");

  // an empty input register always takes a sample
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> sample.ready)
    else $error("input stalled while empty");
`endif

endmodule

// ===== dv/aqd_position_checker.sv =====
// ----------------------------------------------------------------------------
// aqd_position_checker
// Watches the configuration, sample and result channels of the decoder. It
// keeps its own copy of the decode state, predicts the result of every
// accepted sample and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module aqd_position_checker (
  input  logic  clk,
  input  logic  rst,
  aqd_cfg_if    cfg,
  aqd_sample_if sample,
  aqd_result_if result,
  output int    fail_count,
  output int    pending,
  output int    checked,
  output int    up_steps,
  output int    down_steps,
  output int    zero_steps
);
  import aqd_pkg::*;

  localparam int MAX_REPORTS = 10;

  // one predicted result transfer
  typedef struct packed {
    logic [POS_OUT_W-1:0] position;
    logic [STEP_W-1:0]    step_applied;
  } decode_out_t;

  cfg_t                 cur_cfg;
  logic [AB_W-1:0]      prev_lines;
  logic [NOW_W-1:0]     up_time;
  logic [NOW_W-1:0]     down_time;
  logic [POS_OUT_W-1:0] pos_count;
  decode_out_t          expected_q[$];
  decode_out_t          want;

  // thresholds are tried fast first, so a low medium threshold never wins
  function automatic logic [SIZE_W-1:0] size_for(input logic [NOW_W-1:0] elapsed);
    if (elapsed < cur_cfg.fast_interval) return cur_cfg.fast_step;
    if (elapsed < cur_cfg.medium_interval) return cur_cfg.medium_step;
    return SLOW_STEP;
  endfunction

  // update the decode state for one sample and queue its result
  task automatic decode_sample(input logic [AB_W-1:0] ab, input logic [NOW_W-1:0] now);
    logic [SIZE_W-1:0] size;
    logic [NOW_W-1:0]  elapsed;
    logic [STEP_W-1:0] delta;
    decode_out_t       res;
    delta = '0;
    if (ab[LINE_B] != prev_lines[LINE_B]) begin
      if (ab[LINE_A] != ab[LINE_B]) begin
        elapsed = now - up_time;
        size = size_for(elapsed);
        up_time = now;
        delta = STEP_W'(size);
        up_steps++;
      end else begin
        elapsed = now - down_time;
        size = size_for(elapsed);
        down_time = now;
        delta = -STEP_W'(size);
        down_steps++;
      end
      if (size == '0) zero_steps++;
      pos_count = pos_count + {{(POS_OUT_W-STEP_W){delta[STEP_W-1]}}, delta};
    end
    prev_lines = ab;
    res.position = pos_count;
    res.step_applied = delta;
    expected_q.push_back(res);
  endtask

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // results are checked before the same edge's sample is queued
  always @(posedge clk) begin
    if (rst) begin
      cur_cfg.fast_interval = FAST_INTERVAL_RST;
      cur_cfg.medium_interval = MEDIUM_INTERVAL_RST;
      cur_cfg.fast_step = FAST_STEP_RST;
      cur_cfg.medium_step = MEDIUM_STEP_RST;
      prev_lines = '0;
      up_time = '0;
      down_time = '0;
      pos_count = '0;
      expected_q.delete();
    end else begin
      // register write transfer, unknown indexes are dropped
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FAST_INTERVAL:   cur_cfg.fast_interval = cfg.data;
          REG_MEDIUM_INTERVAL: cur_cfg.medium_interval = cfg.data;
          REG_FAST_STEP:       cur_cfg.fast_step = cfg.data[SIZE_W-1:0];
          REG_MEDIUM_STEP:     cur_cfg.medium_step = cfg.data[SIZE_W-1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          flag($sformatf("unexpected result: position %0d step %0d",
                         $signed(result.position), $signed(result.step_applied)));
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (result.position !== want.position ||
              result.step_applied !== want.step_applied) begin
            flag($sformatf("result %0d: got position %0d step %0d, want position %0d step %0d",
                           checked, $signed(result.position), $signed(result.step_applied),
                           $signed(want.position), $signed(want.step_applied)));
          end
        end
      end
      // sample transfer
      if (sample.valid && sample.ready) decode_sample(sample.ab_sample, sample.now_ms);
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the quadrature decoder with encoder samples and register writes.
// Directed samples at reset values come first, then short spins at the
// largest step size in both directions, then phases of random motion and
// noise under several register settings, with bursty sending and a stalling
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import aqd_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RST_CYCLES      = 8;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SPIN_ITEMS      = 40;
  localparam int MOTION_PHASES   = 12;
  localparam int STALL_PATTERN_W = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aqd_cfg_if    cfg_ch();
  aqd_sample_if smp_ch();
  aqd_result_if res_ch();

  int fail_count;
  int pending;
  int checked;
  int up_steps;
  int down_steps;
  int zero_steps;
  int cycle_count = 0;
  int burst_left = 0;
  int cfg_writes = 0;
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  bit turning_up = 1'b1;
  logic [STALL_PATTERN_W-1:0] stall_mask = '1;
  logic [NOW_W-1:0] clock_ms = '0;
  logic [AB_W-1:0] lines_now = '0;

  accelerated_quadrature_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp_ch),
    .result (res_ch)
  );

  aqd_position_checker position_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .sample     (smp_ch),
    .result     (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .up_steps   (up_steps),
    .down_steps (down_steps),
    .zero_steps (zero_steps)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls on a rotating bit pattern
  always @(negedge clk) begin
    if (stall_on) begin
      res_ch.ready = stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[STALL_PATTERN_W-1:1]};
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_writes++;
  endtask

  // hold the sample side until every result has come back
  task automatic wait_idle();
    smp_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] fast_ms,
                            input logic [CFG_DATA_W-1:0] medium_ms,
                            input logic [CFG_DATA_W-1:0] fast_size,
                            input logic [CFG_DATA_W-1:0] medium_size);
    wait_idle();
    write_reg(REG_FAST_INTERVAL, fast_ms);
    write_reg(REG_MEDIUM_INTERVAL, medium_ms);
    write_reg(REG_FAST_STEP, fast_size);
    write_reg(REG_MEDIUM_STEP, medium_size);
  endtask

  // one sample transfer, with a random gap between bursts
  task automatic send_sample(input logic [AB_W-1:0] ab, input logic [NOW_W-1:0] now);
    if (gaps_on && burst_left == 0) begin
      smp_ch.valid = 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(15, 40) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    smp_ch.valid = 1'b1;
    smp_ch.ab_sample = ab;
    smp_ch.now_ms = now;
    do @(posedge clk); while (!smp_ch.ready);
    @(negedge clk);
    lines_now = ab;
    if (burst_left > 0) burst_left--;
  endtask

  // mostly clean gray-code motion with dwells and reversals, some noise
  task automatic run_motion(input int count);
    logic [AB_W-1:0] ab;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        ab = AB_W'($urandom);
        clock_ms = NOW_W'($urandom);
      end else begin
        if ($urandom_range(0, 9) == 0) turning_up = !turning_up;
        ab = lines_now;
        if ($urandom_range(0, 4) != 0) begin
          // up order 0 2 3 1, down order 0 1 3 2
          case (lines_now)
            2'b00: ab = turning_up ? 2'b10 : 2'b01;
            2'b10: ab = turning_up ? 2'b11 : 2'b00;
            2'b11: ab = turning_up ? 2'b01 : 2'b10;
            default: ab = turning_up ? 2'b00 : 2'b11;
          endcase
        end
        case ($urandom_range(0, 3))
          0: clock_ms += NOW_W'($urandom_range(0, 40));
          1: clock_ms += NOW_W'($urandom_range(0, 250));
          2: clock_ms += NOW_W'($urandom_range(0, 3000));
          default: clock_ms += NOW_W'($urandom);
        endcase
      end
      send_sample(ab, clock_ms);
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FAST_INTERVAL;
    cfg_ch.data = '0;
    smp_ch.valid = 1'b0;
    smp_ch.ab_sample = '0;
    smp_ch.now_ms = '0;
    res_ch.ready = 1'b1;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: idle lines, A alone, each size band, time wrap
    send_sample(2'b00, 16'd0);
    send_sample(2'b01, 16'd7);
    send_sample(2'b11, 16'd20);
    send_sample(2'b10, 16'd45);
    send_sample(2'b00, 16'd90);
    send_sample(2'b10, 16'd130);
    send_sample(2'b11, 16'd131);
    send_sample(2'b01, 16'd160);
    send_sample(2'b01, 16'hFFFF);
    send_sample(2'b00, 16'hFFFF);
    send_sample(2'b10, 16'd0);
    send_sample(2'b11, 16'd0);
    send_sample(2'b01, 16'd65500);
    send_sample(2'b11, 16'd10);
    send_sample(2'b01, 16'd30);
    send_sample(2'b11, 16'd40);
    send_sample(2'b10, 16'd49);
    send_sample(2'b00, 16'd89);
    send_sample(2'b10, 16'd139);
    send_sample(2'b01, 16'hAAAA);
    send_sample(2'b10, 16'h5555);
    send_sample(2'b01, 16'hFFFF);

    // widest thresholds and sizes: spin up, then back down
    set_config('1, '1, CFG_DATA_W'(4'hF), CFG_DATA_W'(4'hF));
    for (int k = 0; k < SPIN_ITEMS; k++) begin
      clock_ms += NOW_W'($urandom_range(0, 40));
      send_sample(k[0] ? 2'b01 : 2'b10, clock_ms);
    end
    for (int k = 0; k < SPIN_ITEMS; k++) begin
      clock_ms += NOW_W'($urandom_range(0, 40));
      send_sample(k[0] ? 2'b00 : 2'b11, clock_ms);
    end

    for (int ph = 0; ph < MOTION_PHASES; ph++) begin
      case (ph)
        // zero thresholds: every step is size one
        0: set_config('0, '0, '0, '0);
        // fast size zero, medium threshold never reached
        1: set_config('1, '0, '0, CFG_DATA_W'(4'hF));
        // medium size zero
        2: set_config(16'd30, 16'd200, CFG_DATA_W'(4'hF), '0);
        // thresholds in reverse order
        3: set_config(16'd200, 16'd30, 16'd7, 16'd9);
        default: begin
          set_config($urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom) :
                                                 CFG_DATA_W'($urandom_range(0, 300)),
                     $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom) :
                                                 CFG_DATA_W'($urandom_range(0, 600)),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
          // write to an unused index, which must change nothing
          if (ph[0]) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_MEDIUM_STEP + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
          end
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 2) != 0);
      stall_mask = STALL_PATTERN_W'($urandom) | STALL_PATTERN_W'(1);
      run_motion($urandom_range(10, 16));
      // hold the sender until the result side has caught up
      if (ph == MOTION_PHASES / 2) wait_idle();
      run_motion($urandom_range(8, 14));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d results: %0d up steps, %0d down steps, %0d with zero size",
             checked, up_steps, down_steps, zero_steps);
    $display("%0d register writes, spins at the largest size in both directions", cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
